/* hw/rtl/circular_deque_core_assert.svh */
// circular_deque_core_assert.svh: assertion macros for the deque core
// no dependencies; included by files that carry concurrent assertions
`ifndef CIRCULAR_DEQUE_CORE_ASSERT_SVH
`define CIRCULAR_DEQUE_CORE_ASSERT_SVH

// checked on every edge, reset disables the check
`define CDQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked on every edge, also during reset
`define CDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/cdq_pkg.sv */
// cdq_pkg: constants, types and index helpers for the circular deque core
// no dependencies; used by cdq_ctrl, cdq_datapath and circular_deque_core
package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DATA_W-1:0] data_t;

    // command codes
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_REAR   = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);

    typedef enum logic {
        S_IDLE,
        S_POP_READ
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic load_imm;   // load result decided at accept
        logic load_read;  // load result from slot read data
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic need_read;  // presented command is a pop of a held element
    } dp_stat_t;

    function automatic idx_t idx_next(input idx_t i);
        return (i == IDX_LAST) ? '0 : idx_t'(i + idx_t'(1));
    endfunction

    function automatic idx_t idx_prev(input idx_t i);
        return (i == '0) ? IDX_LAST : idx_t'(i - idx_t'(1));
    endfunction

endpackage

/* hw/rtl/cdq_ctrl.sv */
// cdq_ctrl: sequencing state machine of the circular deque core
// depends on cdq_pkg
module cdq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cdq_pkg::dp_stat_t dp_stat,
    output cdq_pkg::ctl_cmd_t ctl_cmd
);

    cdq_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cdq_pkg::S_IDLE: begin
                if (s_tvalid && dp_stat.out_free && dp_stat.need_read) begin
                    state_next = cdq_pkg::S_POP_READ;
                end
            end
            cdq_pkg::S_POP_READ: begin
                if (dp_stat.out_free) begin
                    state_next = cdq_pkg::S_IDLE;
                end
            end
            default: state_next = cdq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready          = 1'b0;
        ctl_cmd.accept    = 1'b0;
        ctl_cmd.load_imm  = 1'b0;
        ctl_cmd.load_read = 1'b0;
        unique case (state_reg)
            cdq_pkg::S_IDLE: begin
                s_tready         = dp_stat.out_free;
                ctl_cmd.accept   = s_tvalid && dp_stat.out_free;
                ctl_cmd.load_imm = s_tvalid && dp_stat.out_free && !dp_stat.need_read;
            end
            cdq_pkg::S_POP_READ: begin
                ctl_cmd.load_read = dp_stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/cdq_datapath.sv */
// cdq_datapath: slot memory, front/rear pointers, empty flag and result register
// depends on cdq_pkg
module cdq_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        command,
    input  logic [31:0]       push_value,
    input  cdq_pkg::ctl_cmd_t ctl_cmd,
    output cdq_pkg::dp_stat_t dp_stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [1:0]        m_tuser
);

    cdq_pkg::data_t slots_mem [cdq_pkg::DEPTH];
    cdq_pkg::data_t rd_data_reg;

    cdq_pkg::idx_t front_reg, front_next;
    cdq_pkg::idx_t rear_reg, rear_next;
    logic          empty_reg, empty_next;

    logic          out_valid_reg;
    logic [31:0]   out_data_reg;
    logic [1:0]    out_stat_reg;

    logic          is_pop, is_full;
    logic          wr_en, rd_en;
    cdq_pkg::idx_t wr_addr, rd_addr;
    logic [1:0]    imm_stat;

    assign is_pop  = (command == cdq_pkg::CMD_POP_FRONT) || (command == cdq_pkg::CMD_POP_REAR);
    assign is_full = !empty_reg && (cdq_pkg::idx_next(rear_reg) == front_reg);

    assign dp_stat.out_free  = !out_valid_reg || m_tready;
    assign dp_stat.need_read = is_pop && !empty_reg;

    // pointer update, slot write and slot read for the accepted command
    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        imm_stat   = cdq_pkg::STAT_OK;
        if (!is_pop) begin
            priority if (is_full) begin
                imm_stat = cdq_pkg::STAT_FULL;
            end else if (empty_reg) begin
                front_next = '0;
                rear_next  = '0;
                empty_next = 1'b0;
                wr_en      = ctl_cmd.accept;
            end else if (command == cdq_pkg::CMD_PUSH_FRONT) begin
                front_next = cdq_pkg::idx_prev(front_reg);
                wr_addr    = front_next;
                wr_en      = ctl_cmd.accept;
            end else begin
                rear_next = cdq_pkg::idx_next(rear_reg);
                wr_addr   = rear_next;
                wr_en     = ctl_cmd.accept;
            end
        end else begin
            priority if (empty_reg) begin
                imm_stat = cdq_pkg::STAT_EMPTY;
            end else if (front_reg == rear_reg) begin
                // last element leaves, pointers return home
                rd_addr    = front_reg;
                rd_en      = ctl_cmd.accept;
                front_next = '0;
                rear_next  = '0;
                empty_next = 1'b1;
            end else if (command == cdq_pkg::CMD_POP_FRONT) begin
                rd_addr    = front_reg;
                rd_en      = ctl_cmd.accept;
                front_next = cdq_pkg::idx_next(front_reg);
            end else begin
                rd_addr   = rear_reg;
                rd_en     = ctl_cmd.accept;
                rear_next = cdq_pkg::idx_prev(rear_reg);
            end
        end
    end

    // pointer and empty flag registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (ctl_cmd.accept) begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
        end
    end

    // slot memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slots_mem[wr_addr] <= push_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= slots_mem[rd_addr];
        end
    end

    // result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl_cmd.load_imm || ctl_cmd.load_read) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (ctl_cmd.load_imm) begin
            out_data_reg <= '0;
            out_stat_reg <= imm_stat;
        end else if (ctl_cmd.load_read) begin
            out_data_reg <= rd_data_reg;
            out_stat_reg <= cdq_pkg::STAT_OK;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;

endmodule

/* hw/rtl/circular_deque_core.sv */
// circular_deque_core: double-ended queue in a circular slot memory, top level
// depends on cdq_pkg, cdq_ctrl, cdq_datapath and circular_deque_core_assert.svh
//
// channel   dir   tdata                     tuser
// s_        in    [31:0] push_value         [1:0] command
// m_        out   [31:0] pop_value          [1:0] status
//
// a push or a failed pop has its result loaded into the output register at the input transfer
// a successful pop first reads the slot memory into a register, then loads the result in S_POP_READ
// one command is in work at a time; the output register holds a result
// while the next command is taken if the result is being drained that cycle
// synchronous active-low reset empties the deque; no clearing pass is needed
`include "circular_deque_core_assert.svh"

module circular_deque_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] pop_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    cdq_pkg::ctl_cmd_t ctl_cmd;
    cdq_pkg::dp_stat_t dp_stat;

    // sequencing
    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_stat  (dp_stat),
        .ctl_cmd  (ctl_cmd)
    );

    // storage and result
    cdq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .command    (s_tuser),
        .push_value (s_tdata),
        .ctl_cmd    (ctl_cmd),
        .dp_stat    (dp_stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // assertions
    `CDQ_ASSERT_ALWAYS(a_reset_no_result, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `CDQ_ASSERT(a_pop_read_blocks, aclk, aresetn, (s_tvalid && s_tready && dp_stat.need_read) |=> !s_tready, "input taken while a pop read is pending")
    `CDQ_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> (m_tuser == cdq_pkg::STAT_OK || m_tuser == cdq_pkg::STAT_FULL || m_tuser == cdq_pkg::STAT_EMPTY), "bad status code")
    `CDQ_ASSERT(a_fail_zero_value, aclk, aresetn, (m_tvalid && m_tuser != cdq_pkg::STAT_OK) |-> (m_tdata == 32'd0), "failed command carries a value")

endmodule

/* tb/sv/circular_deque_core_checker.sv */
// circular_deque_core_checker: watches both stream channels of the deque core,
// predicts each command's outcome and compares it with the result transfer
// depends on cdq_pkg for the data and index types and the command and status codes
`timescale 1ns / 1ps

module circular_deque_core_checker
    import cdq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] pop_value
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        data_t      pop_value;
        logic [1:0] status;
    } outcome_t;

    // shadow copy of the deque
    data_t    slot_mem [DEPTH];
    idx_t     front_idx;
    idx_t     rear_idx;
    logic     deque_empty;
    outcome_t outcome_q [$];
    outcome_t want;

    function automatic idx_t wrap_up(input idx_t i);
        return (int'(i) == DEPTH - 1) ? idx_t'(0) : idx_t'(int'(i) + 1);
    endfunction

    function automatic idx_t wrap_down(input idx_t i);
        return (int'(i) == 0) ? idx_t'(DEPTH - 1) : idx_t'(int'(i) - 1);
    endfunction

    // applies one command to the shadow deque and returns its outcome
    function automatic outcome_t apply_command(input logic [1:0] cmd, input data_t val);
        outcome_t o;
        logic     is_full;
        o.pop_value = '0;
        o.status    = STAT_OK;
        is_full     = !deque_empty && (wrap_up(rear_idx) == front_idx);
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
            if (is_full) begin
                o.status = STAT_FULL;
            end else if (deque_empty) begin
                front_idx   = '0;
                rear_idx    = '0;
                slot_mem[0] = val;
                deque_empty = 1'b0;
            end else if (cmd == CMD_PUSH_FRONT) begin
                front_idx           = wrap_down(front_idx);
                slot_mem[front_idx] = val;
            end else begin
                rear_idx           = wrap_up(rear_idx);
                slot_mem[rear_idx] = val;
            end
        end else begin
            if (deque_empty) begin
                o.status = STAT_EMPTY;
            end else if (front_idx == rear_idx) begin
                // last element leaves, pointers go home
                o.pop_value = slot_mem[front_idx];
                front_idx   = '0;
                rear_idx    = '0;
                deque_empty = 1'b1;
            end else if (cmd == CMD_POP_FRONT) begin
                o.pop_value = slot_mem[front_idx];
                front_idx   = wrap_up(front_idx);
            end else begin
                o.pop_value = slot_mem[rear_idx];
                rear_idx    = wrap_down(rear_idx);
            end
        end
        return o;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
        for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
        front_idx   = '0;
        rear_idx    = '0;
        deque_empty = 1'b1;
    end

    // sample both channels at each edge, result side first
    always @(posedge aclk) begin
        if (!aresetn) begin
            front_idx   = '0;
            rear_idx    = '0;
            deque_empty = 1'b1;
            outcome_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result transfer with none expected: value %h status %0d",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_tdata !== want.pop_value) begin
                        $display("%0t: pop_value expected %h actual %h",
                                 $time, want.pop_value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(apply_command(s_tuser, s_tdata));
            end
        end
        pending = outcome_q.size();
    end

endmodule

/* tb/sv/circular_deque_core_tb.sv */
// circular_deque_core_tb: drives commands into the deque core with random gaps
// and back-pressure, and gives the verdict from the checker's failure count
// depends on cdq_pkg, circular_deque_core and circular_deque_core_checker
`timescale 1ns / 1ps

module circular_deque_core_tb;
    import cdq_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] push_value
    logic [1:0]  s_tuser  = '0;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] pop_value
    logic [1:0]  m_tuser;         // [1:0] status
    int          fail_count;
    int          pending;
    bit          quiet    = 1'b0; // no idling on either side while set

    always #4 aclk = ~aclk;

    circular_deque_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    circular_deque_core_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 32);
    end

    // one command transfer, with a random gap ahead of it
    task automatic send_cmd(input logic [1:0] cmd, input data_t val);
        while (!quiet && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // values leaning on the extremes
    function automatic data_t pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return data_t'($urandom);
        endcase
    endfunction

    initial begin
        int         n;
        int         run_len;
        int         push_pct;
        logic [1:0] cmd;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pops on an empty deque, single-element push and pop
        send_cmd(CMD_POP_FRONT, 32'h1234_5678);
        send_cmd(CMD_POP_REAR, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_PUSH_REAR, 32'h8000_0000);
        send_cmd(CMD_POP_FRONT, 32'h0);
        // fill from both ends so the pointers wrap
        send_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
        send_cmd(CMD_PUSH_REAR, 32'hAAAA_AAAA);
        send_cmd(CMD_PUSH_FRONT, 32'h5555_5555);
        send_cmd(CMD_PUSH_REAR, 32'h0000_0001);
        send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
        send_cmd(CMD_PUSH_REAR, 32'h7FFF_FFFF);
        send_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFE);
        // pushes to a full deque get dropped
        send_cmd(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
        send_cmd(CMD_PUSH_REAR, 32'hCAFE_F00D);
        // drain across the wrap point down to empty
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_REAR, 32'h0);
        send_cmd(CMD_POP_FRONT, 32'h0);
        send_cmd(CMD_POP_FRONT, 32'h0);

        // runs biased toward filling, draining or balance
        n = 0;
        while (n < 1500) begin
            case ($urandom_range(2))
                0:       push_pct = 75;
                1:       push_pct = 25;
                default: push_pct = 50;
            endcase
            run_len = $urandom_range(4, 20);
            for (int k = 0; k < run_len && n < 1500; k++) begin
                if ($urandom_range(99) < push_pct)
                    cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
                else
                    cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
                quiet = (n >= 600 && n < 900);
                send_cmd(cmd, pick_value());
                n++;
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // let the checker count the last transfer, then drain every result
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("circular_deque_core_tb OK");
        else
            $display("circular_deque_core_tb NOT OK");
        $finish;
    end

    // hang guard
    initial begin
        #2ms;
        $display("circular_deque_core_tb NOT OK");
        $finish;
    end

endmodule
